// ===== design/cmme_pkg.sv =====
package cmme_pkg;

  localparam int SAMPLE_W = 16;
  localparam int COLUMN_W = 10;
  localparam int COUNT_W  = 11;

  // operation codes, code 3 has no meaning
  typedef enum logic [1:0] {
    OP_ADD   = 2'd0,
    OP_READ  = 2'd1,
    OP_CLEAR = 2'd2
  } cmme_op_t;

  typedef struct packed {
    logic [1:0]                  operation;
    logic [COLUMN_W-1:0]         column;
    logic signed [SAMPLE_W-1:0]  sample_value;
  } cmme_in_t;

  typedef struct packed {
    logic                        accepted;
    logic                        column_used;
    logic signed [SAMPLE_W-1:0]  column_low;
    logic signed [SAMPLE_W-1:0]  column_high;
    logic                        any_used;
    logic signed [SAMPLE_W-1:0]  total_low;
    logic signed [SAMPLE_W-1:0]  total_high;
    logic [COUNT_W-1:0]          used_count;
  } cmme_out_t;

  // one column entry of the envelope memory
  typedef struct packed {
    logic signed [SAMPLE_W-1:0]  low;
    logic signed [SAMPLE_W-1:0]  high;
  } cmme_ent_t;

  // update request from the compute stage to the running totals
  typedef struct packed {
    logic                        fold;
    logic                        first;
    logic                        clear;
    logic signed [SAMPLE_W-1:0]  value;
  } cmme_upd_t;

endpackage

// ===== design/cmme_store.sv =====
module cmme_store #(
  parameter int DEPTH = 160,
  parameter int AW    = 8
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                rd_en,
  input  logic [AW-1:0]       rd_addr,
  output cmme_pkg::cmme_ent_t rd_data,
  input  logic                wr_en,
  input  logic [AW-1:0]       wr_addr,
  input  cmme_pkg::cmme_ent_t wr_data,
  input  logic [AW-1:0]       mark_addr,
  output logic                mark,
  input  logic                clear_all
);

  cmme_pkg::cmme_ent_t mem_r [DEPTH];
  cmme_pkg::cmme_ent_t rd_data_r;
  logic [DEPTH-1:0]    marks_r;

  // used marks, cleared at once by reset or clear
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      marks_r <= '0;
    end else if (clear_all) begin
      marks_r <= '0;
    end else if (wr_en) begin
      marks_r[wr_addr] <= 1'b1;
    end
  end

  // mark lookup for the entry in the compute stage
  assign mark = ({1'b0, mark_addr} < (AW+1)'(DEPTH)) ? marks_r[mark_addr] : 1'b0;

  // envelope memory write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
  end

  // registered read, bypass when the same entry is written this cycle
  always_ff @(posedge clk) begin
    if (rd_en) begin
      if (wr_en && (wr_addr == rd_addr)) begin
        rd_data_r <= wr_data;
      end else begin
        rd_data_r <= mem_r[rd_addr];
      end
    end
  end

  assign rd_data = rd_data_r;

  a_clear_empties: assert property (@(posedge clk) disable iff (!rst_n)
    clear_all |=> (marks_r == '0))
    else $error("marks not empty after clear");

  a_write_marks: assert property (@(posedge clk) disable iff (!rst_n)
    (wr_en && !clear_all) |=> marks_r[$past(wr_addr)])
    else $error("written entry not marked used");

  a_bypass: assert property (@(posedge clk) disable iff (!rst_n)
    (rd_en && wr_en && (rd_addr == wr_addr)) |=> (rd_data_r == $past(wr_data)))
    else $error("read missed same-cycle write");

endmodule

// ===== design/cmme_totals.sv =====
module cmme_totals (
  input  logic                                clk,
  input  logic                                rst_n,
  input  cmme_pkg::cmme_upd_t                 upd,
  output logic signed [cmme_pkg::SAMPLE_W-1:0] low_nxt,
  output logic signed [cmme_pkg::SAMPLE_W-1:0] high_nxt,
  output logic [cmme_pkg::COUNT_W-1:0]        count_nxt
);

  logic signed [cmme_pkg::SAMPLE_W-1:0] low_r;
  logic signed [cmme_pkg::SAMPLE_W-1:0] high_r;
  logic [cmme_pkg::COUNT_W-1:0]         count_r;

  // running overall envelope and used count
  always_comb begin
    low_nxt   = low_r;
    high_nxt  = high_r;
    count_nxt = count_r;
    if (upd.clear) begin
      low_nxt   = '0;
      high_nxt  = '0;
      count_nxt = '0;
    end else if (upd.fold) begin
      if (count_r == '0) begin
        low_nxt  = upd.value;
        high_nxt = upd.value;
      end else begin
        if (upd.value < low_r) low_nxt = upd.value;
        if (upd.value > high_r) high_nxt = upd.value;
      end
      if (upd.first) begin
        count_nxt = count_r + cmme_pkg::COUNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      low_r   <= '0;
      high_r  <= '0;
      count_r <= '0;
    end else begin
      low_r   <= low_nxt;
      high_r  <= high_nxt;
      count_r <= count_nxt;
    end
  end

  a_order: assert property (@(posedge clk) disable iff (!rst_n)
    (count_r != '0) |-> (low_r <= high_r))
    else $error("overall low above overall high");

  a_clear: assert property (@(posedge clk) disable iff (!rst_n)
    upd.clear |=> ((count_r == '0) && (low_r == '0) && (high_r == '0)))
    else $error("totals not reset by clear");

  a_empty_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (count_r == '0) |-> ((low_r == '0) && (high_r == '0)))
    else $error("empty table with nonzero totals");

endmodule

// ===== design/column_min_max_envelope_table.sv =====
// channel  direction  handshake             payload
// in_      input      in_valid / in_stall   cmme_in_t  operation, column, sample_value
// out_     output     out_valid / out_stall cmme_out_t envelope of column and table
//
// one item per cycle sustained while out_stall is low; a result passes the input register,
// then the result register, and is held there while out_stall is high
// the envelope memory is read while the item enters the input register
// reset clears the used marks and totals at once; no clearing pass
// out_stall holds the result; one further item is still taken into the input stage
// in_stall rises only while the input stage is full and the result is stalled
module column_min_max_envelope_table #(
  parameter int COLUMNS = 160
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  cmme_pkg::cmme_in_t  in_data,
  output logic                out_valid,
  input  logic                out_stall,
  output cmme_pkg::cmme_out_t out_data
);

  localparam int AW = (COLUMNS > 1) ? $clog2(COLUMNS) : 1;
  localparam logic [cmme_pkg::COLUMN_W:0] COL_LIMIT = (cmme_pkg::COLUMN_W+1)'(COLUMNS);

  logic                 s1_valid_r;
  cmme_pkg::cmme_in_t   s1_data_r;
  logic                 out_valid_r;
  cmme_pkg::cmme_out_t  out_data_r;

  logic                 in_xfer;
  logic                 advance;
  logic                 s1_fire;
  logic                 in_rng;
  logic [AW-1:0]        s1_idx;
  logic                 mark;
  cmme_pkg::cmme_ent_t  rd_ent;
  cmme_pkg::cmme_ent_t  new_ent;
  logic                 wr_en;
  cmme_pkg::cmme_upd_t  upd;
  logic                 acc;
  logic                 cu;
  logic signed [cmme_pkg::SAMPLE_W-1:0] cl;
  logic signed [cmme_pkg::SAMPLE_W-1:0] ch;
  logic signed [cmme_pkg::SAMPLE_W-1:0] low_nxt;
  logic signed [cmme_pkg::SAMPLE_W-1:0] high_nxt;
  logic [cmme_pkg::COUNT_W-1:0]         count_nxt;

  // handshake control
  assign advance  = !out_valid_r || !out_stall;
  assign in_stall = s1_valid_r && !advance;
  assign in_xfer  = in_valid && !in_stall;
  assign s1_fire  = s1_valid_r && advance;

  // input stage register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_xfer) begin
      s1_valid_r <= 1'b1;
    end else if (s1_fire) begin
      s1_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer) begin
      s1_data_r <= in_data;
    end
  end

  assign in_rng = {1'b0, s1_data_r.column} < COL_LIMIT;
  assign s1_idx = s1_data_r.column[AW-1:0];

  cmme_store #(
    .DEPTH (COLUMNS),
    .AW    (AW)
  ) u_store (
    .clk       (clk),
    .rst_n     (rst_n),
    .rd_en     (in_xfer),
    .rd_addr   (in_data.column[AW-1:0]),
    .rd_data   (rd_ent),
    .wr_en     (wr_en),
    .wr_addr   (s1_idx),
    .wr_data   (new_ent),
    .mark_addr (s1_idx),
    .mark      (mark),
    .clear_all (upd.clear)
  );

  // widen the column envelope with the sample
  always_comb begin
    new_ent.low  = (!mark || (s1_data_r.sample_value < rd_ent.low)) ?
                   s1_data_r.sample_value : rd_ent.low;
    new_ent.high = (!mark || (s1_data_r.sample_value > rd_ent.high)) ?
                   s1_data_r.sample_value : rd_ent.high;
  end

  // operation decode and column result
  always_comb begin
    acc       = 1'b0;
    cu        = 1'b0;
    cl        = '0;
    ch        = '0;
    wr_en     = 1'b0;
    upd.fold  = 1'b0;
    upd.first = 1'b0;
    upd.clear = 1'b0;
    upd.value = s1_data_r.sample_value;
    unique case (s1_data_r.operation)
      cmme_pkg::OP_ADD: begin
        if (in_rng) begin
          acc       = 1'b1;
          cu        = 1'b1;
          cl        = new_ent.low;
          ch        = new_ent.high;
          wr_en     = s1_fire;
          upd.fold  = s1_fire;
          upd.first = !mark;
        end
      end
      cmme_pkg::OP_READ: begin
        if (in_rng) begin
          acc = 1'b1;
          cu  = mark;
          if (mark) begin
            cl = rd_ent.low;
            ch = rd_ent.high;
          end
        end
      end
      cmme_pkg::OP_CLEAR: begin
        acc       = 1'b1;
        upd.clear = s1_fire;
      end
      default: begin
      end
    endcase
  end

  cmme_totals u_totals (
    .clk       (clk),
    .rst_n     (rst_n),
    .upd       (upd),
    .low_nxt   (low_nxt),
    .high_nxt  (high_nxt),
    .count_nxt (count_nxt)
  );

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s1_fire) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_fire) begin
      out_data_r.accepted    <= acc;
      out_data_r.column_used <= cu;
      out_data_r.column_low  <= cl;
      out_data_r.column_high <= ch;
      out_data_r.any_used    <= (count_nxt != '0);
      out_data_r.total_low   <= (count_nxt != '0) ? low_nxt : '0;
      out_data_r.total_high  <= (count_nxt != '0) ? high_nxt : '0;
      out_data_r.used_count  <= count_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  a_stall_full: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> (s1_valid_r && out_valid_r))
    else $error("input stalled with room in the pipeline");

  a_any_used: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (out_data_r.any_used == (out_data_r.used_count != '0)))
    else $error("any_used disagrees with used_count");

  a_empty_totals: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_data_r.any_used) |->
      ((out_data_r.total_low == '0) && (out_data_r.total_high == '0)))
    else $error("totals reported for empty table");

  a_column_order: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_data_r.column_used) |->
      (out_data_r.column_low <= out_data_r.column_high))
    else $error("column low above column high");

endmodule

// ===== tb/tb_top.sv =====
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int COLUMNS = 160;
  localparam int LIMIT_CYCLES = 200000;
  localparam int HOLD_CYCLES = 60;
  localparam int TAIL_CYCLES = 8;
  localparam logic [1:0] OP_UNUSED = 2'd3;

  typedef enum logic [1:0] {
    SK_ITEM,
    SK_DRAIN,
    SK_HOLD,
    SK_QUIET
  } stim_kind_t;

  typedef struct {
    stim_kind_t          kind;
    cmme_pkg::cmme_in_t  item;
    bit                  flag;
  } stim_t;

  logic                 clk = 1'b0;
  logic                 rst_n = 1'b0;
  logic                 in_valid = 1'b0;
  logic                 in_stall;
  cmme_pkg::cmme_in_t   in_data = '0;
  logic                 out_valid;
  logic                 out_stall = 1'b0;
  cmme_pkg::cmme_out_t  out_data;

  column_min_max_envelope_table #(
    .COLUMNS(COLUMNS)
  ) u_top (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data (out_data)
  );

  // clock
  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // shadow copy of the envelope table
  bit                                shadow_used [COLUMNS];
  logic signed [15:0]                shadow_low [COLUMNS];
  logic signed [15:0]                shadow_high [COLUMNS];
  logic signed [15:0]                shadow_total_low = '0;
  logic signed [15:0]                shadow_total_high = '0;
  logic [cmme_pkg::COUNT_W-1:0]      shadow_count = '0;

  stim_t                stim_q[$];
  cmme_pkg::cmme_out_t  envelope_q[$];

  int  errors = 0;
  int  cycles = 0;
  int  items_taken = 0;
  int  results_seen = 0;
  int  clears_taken = 0;
  int  rejects_taken = 0;
  int  peak_used = 0;
  logic in_xfer = 1'b0;
  logic quiet = 1'b0;
  int  holds_asked = 0;
  int  holds_done = 0;
  int  hold_left = 0;
  int  stall_burst = 0;
  int  send_gap = 0;
  bit  drain_wait = 1'b0;

  // fold one transfer into the shadow table and return the expected result
  function automatic cmme_pkg::cmme_out_t fold_envelope(cmme_pkg::cmme_in_t it);
    cmme_pkg::cmme_out_t r;
    int c;
    r = '0;
    c = int'(it.column);
    if (it.operation == cmme_pkg::OP_CLEAR) begin
      for (int i = 0; i < COLUMNS; i++) shadow_used[i] = 1'b0;
      shadow_total_low = '0;
      shadow_total_high = '0;
      shadow_count = '0;
      r.accepted = 1'b1;
      clears_taken++;
    end else if ((it.operation == cmme_pkg::OP_ADD || it.operation == cmme_pkg::OP_READ)
                 && c < COLUMNS) begin
      r.accepted = 1'b1;
      if (it.operation == cmme_pkg::OP_ADD) begin
        if (!shadow_used[c]) begin
          // first sample of a column sets both bounds
          shadow_used[c] = 1'b1;
          shadow_low[c] = it.sample_value;
          shadow_high[c] = it.sample_value;
          if (shadow_count == 0) begin
            shadow_total_low = it.sample_value;
            shadow_total_high = it.sample_value;
          end else begin
            if (it.sample_value < shadow_total_low) shadow_total_low = it.sample_value;
            if (it.sample_value > shadow_total_high) shadow_total_high = it.sample_value;
          end
          shadow_count = shadow_count + 1'b1;
        end else begin
          if (it.sample_value < shadow_low[c]) shadow_low[c] = it.sample_value;
          if (it.sample_value > shadow_high[c]) shadow_high[c] = it.sample_value;
          if (it.sample_value < shadow_total_low) shadow_total_low = it.sample_value;
          if (it.sample_value > shadow_total_high) shadow_total_high = it.sample_value;
        end
      end
      if (shadow_used[c]) begin
        r.column_used = 1'b1;
        r.column_low = shadow_low[c];
        r.column_high = shadow_high[c];
      end
    end else begin
      rejects_taken++;
    end
    r.any_used = (shadow_count != 0);
    r.total_low = (shadow_count != 0) ? shadow_total_low : '0;
    r.total_high = (shadow_count != 0) ? shadow_total_high : '0;
    r.used_count = shadow_count;
    if (int'(shadow_count) > peak_used) peak_used = int'(shadow_count);
    return r;
  endfunction

  task automatic check_field(string name, int want, int got);
    if (want != got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      errors++;
    end
  endtask

  // results against expectations, transfers into the shadow table
  always @(posedge clk) begin : monitor
    cmme_pkg::cmme_out_t want;
    if (!rst_n) begin
      in_xfer <= 1'b0;
    end else begin
      cycles++;
      if (cycles > LIMIT_CYCLES) begin
        $display("tb_top: timeout after %0d cycles", cycles);
        $display("tb_top: done, errors");
        $finish;
      end else begin
        if (out_valid && !out_stall) begin
          results_seen++;
          if (envelope_q.size() == 0) begin
            $error("result with nothing expected");
            errors++;
          end else begin
            want = envelope_q.pop_front();
            check_field("accepted", int'(want.accepted), int'(out_data.accepted));
            check_field("column_used", int'(want.column_used), int'(out_data.column_used));
            check_field("column_low", int'(want.column_low), int'(out_data.column_low));
            check_field("column_high", int'(want.column_high), int'(out_data.column_high));
            check_field("any_used", int'(want.any_used), int'(out_data.any_used));
            check_field("total_low", int'(want.total_low), int'(out_data.total_low));
            check_field("total_high", int'(want.total_high), int'(out_data.total_high));
            check_field("used_count", int'(want.used_count), int'(out_data.used_count));
          end
        end
        if (in_valid && !in_stall) begin
          in_xfer <= 1'b1;
          items_taken++;
          envelope_q.push_back(fold_envelope(in_data));
        end else begin
          in_xfer <= 1'b0;
        end
      end
    end
  end

  // sender: pops pending items, idles in bursts, obeys pause marks
  always @(negedge clk) begin : driver
    stim_t s;
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (!in_valid || in_xfer) begin
      if (drain_wait) begin
        if (envelope_q.size() == 0) drain_wait = 1'b0;
        in_valid <= 1'b0;
      end else if (send_gap > 0) begin
        send_gap--;
        in_valid <= 1'b0;
      end else if (stim_q.size() == 0) begin
        in_valid <= 1'b0;
      end else if (!quiet && $urandom_range(0, 7) == 0) begin
        send_gap = $urandom_range(0, 4);
        in_valid <= 1'b0;
      end else begin
        s = stim_q.pop_front();
        case (s.kind)
          SK_ITEM: begin
            in_data <= s.item;
            in_valid <= 1'b1;
          end
          SK_DRAIN: begin
            drain_wait = 1'b1;
            in_valid <= 1'b0;
          end
          SK_HOLD: begin
            holds_asked <= holds_asked + 1;
            in_valid <= 1'b0;
          end
          default: begin
            quiet <= s.flag;
            in_valid <= 1'b0;
          end
        endcase
      end
    end
  end

  // receiver: random stall bursts plus a long hold-off on request
  always @(negedge clk) begin : receiver
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left--;
      out_stall <= 1'b1;
    end else if (holds_asked != holds_done) begin
      holds_done++;
      hold_left = HOLD_CYCLES;
      out_stall <= 1'b1;
    end else if (stall_burst > 0) begin
      stall_burst--;
      out_stall <= 1'b1;
    end else if (!quiet && $urandom_range(0, 7) == 0) begin
      stall_burst = $urandom_range(0, 4);
      out_stall <= 1'b1;
    end else begin
      out_stall <= 1'b0;
    end
  end

  function automatic cmme_pkg::cmme_in_t make_item(logic [1:0] op, int col, int val);
    cmme_pkg::cmme_in_t it;
    it.operation = op;
    it.column = col[cmme_pkg::COLUMN_W-1:0];
    it.sample_value = val[cmme_pkg::SAMPLE_W-1:0];
    return it;
  endfunction

  // extremes, small values around zero, or anything
  function automatic int random_sample();
    int pick;
    pick = $urandom_range(0, 9);
    if (pick == 0) return -32768;
    if (pick == 1) return 32767;
    if (pick < 4) return int'($urandom_range(0, 31)) - 16;
    return int'($urandom_range(0, 65535)) - 32768;
  endfunction

  // mostly adds and reads on in-range columns, some clears and junk
  function automatic cmme_pkg::cmme_in_t random_item(int span);
    int pick;
    int col;
    logic [1:0] op;
    pick = $urandom_range(0, 99);
    col = $urandom_range(0, span - 1);
    if (pick < 55) op = cmme_pkg::OP_ADD;
    else if (pick < 85) op = cmme_pkg::OP_READ;
    else if (pick < 87) op = cmme_pkg::OP_CLEAR;
    else if (pick < 95) begin
      op = $urandom_range(0, 1) ? cmme_pkg::OP_ADD : cmme_pkg::OP_READ;
      col = $urandom_range(COLUMNS, 1023);
    end else begin
      op = OP_UNUSED;
      col = $urandom_range(0, 1023);
    end
    return make_item(op, col, random_sample());
  endfunction

  task automatic queue_item(cmme_pkg::cmme_in_t it);
    stim_t s;
    s.kind = SK_ITEM;
    s.item = it;
    s.flag = 1'b0;
    stim_q.push_back(s);
  endtask

  task automatic queue_mark(stim_kind_t kind, bit flag);
    stim_t s;
    s.kind = kind;
    s.item = '0;
    s.flag = flag;
    stim_q.push_back(s);
  endtask

  // stimulus plan and end of run
  initial begin
    // directed: empty table, extremes, rejects, unused code, clears
    queue_item(make_item(cmme_pkg::OP_READ, 0, 0));
    queue_item(make_item(cmme_pkg::OP_ADD, 0, 32767));
    queue_item(make_item(cmme_pkg::OP_ADD, 0, -32768));
    queue_item(make_item(cmme_pkg::OP_READ, 0, 0));
    queue_item(make_item(cmme_pkg::OP_ADD, COLUMNS - 1, 5));
    queue_item(make_item(cmme_pkg::OP_ADD, COLUMNS, 7));
    queue_item(make_item(cmme_pkg::OP_ADD, 1023, -1));
    queue_item(make_item(cmme_pkg::OP_READ, 1023, 0));
    queue_item(make_item(OP_UNUSED, 5, 1));
    queue_item(make_item(OP_UNUSED, 1023, -32768));
    queue_item(make_item(cmme_pkg::OP_ADD, 1, 100));
    queue_item(make_item(cmme_pkg::OP_ADD, 1, 50));
    queue_item(make_item(cmme_pkg::OP_ADD, 1, 200));
    queue_item(make_item(cmme_pkg::OP_READ, 2, 0));
    queue_item(make_item(cmme_pkg::OP_CLEAR, 7, 0));
    queue_item(make_item(cmme_pkg::OP_READ, 0, 0));
    queue_item(make_item(OP_UNUSED, 0, 0));
    queue_item(make_item(cmme_pkg::OP_ADD, 80, -32768));
    queue_item(make_item(cmme_pkg::OP_ADD, 81, -5));
    queue_item(make_item(cmme_pkg::OP_READ, 80, 0));
    queue_item(make_item(cmme_pkg::OP_CLEAR, 1023, -1));
    queue_item(make_item(cmme_pkg::OP_READ, 80, 0));
    queue_item(make_item(cmme_pkg::OP_ADD, 3, 0));
    queue_mark(SK_DRAIN, 1'b0);

    // random over the whole table, with a long receiver hold-off inside
    for (int i = 0; i < 300; i++) queue_item(random_item(COLUMNS));
    queue_mark(SK_HOLD, 1'b0);
    for (int i = 0; i < 120; i++) queue_item(random_item(COLUMNS));
    queue_mark(SK_DRAIN, 1'b0);

    // fill every column, then read some back
    for (int i = 0; i < COLUMNS; i++) begin
      queue_item(make_item(cmme_pkg::OP_ADD, i, random_sample()));
    end
    for (int i = 0; i < 40; i++) begin
      queue_item(make_item(cmme_pkg::OP_READ, $urandom_range(0, COLUMNS - 1), 0));
    end
    queue_item(make_item(cmme_pkg::OP_CLEAR, $urandom_range(0, 1023), 0));

    // a few hot columns so envelopes widen many times
    for (int i = 0; i < 380; i++) queue_item(random_item(8));
    queue_mark(SK_DRAIN, 1'b0);

    // last part without idling on either side
    queue_mark(SK_QUIET, 1'b1);
    for (int i = 0; i < 300; i++) queue_item(random_item($urandom_range(0, 1) ? 16 : COLUMNS));

    repeat (10) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    while (stim_q.size() != 0 || in_valid || drain_wait) @(posedge clk);
    while (envelope_q.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);

    $display("tb_top: %0d transfers in, %0d results checked, %0d clears, %0d rejected",
             items_taken, results_seen, clears_taken, rejects_taken);
    $display("tb_top: peak used count %0d of %0d columns, %0d cycles",
             peak_used, COLUMNS, cycles);
    if (errors == 0) begin
      $display("tb_top: done, clean");
    end else begin
      $display("tb_top: done, errors");
    end
    $finish;
  end

endmodule
